/* hw/rtl/swdft_pkg.sv */
// ============================================================================
// swdft_pkg
// Shared types, widths and the coefficient ROM of the sliding-window DFT
// phasor estimator.
// ============================================================================
package swdft_pkg;

    // Default configuration
    localparam int WINDOW_LEN_DEF  = 50;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int COEF_BITS_DEF   = 16;

    // Fixed field widths
    localparam int ACC_W         = 33;
    localparam int TIME_W        = 14;
    localparam int COUNT_W       = 16;
    localparam int COEF_MAX_BITS = 24;

    // ROM geometry: one full cycle of 50 points, quarter wave stored
    localparam int ROM_LEN = 50;
    localparam int QUARTER = 13;

    // round(32768*cos(2*pi*k/50)) and round(32768*sin(2*pi*k/50)), k = 0..12
    localparam int COS_Q [QUARTER] = '{
        32768, 32510, 31739, 30467, 28715, 26510, 23887,
        20887, 17558, 13952, 10126, 6140, 2058
    };
    localparam int SIN_Q [QUARTER] = '{
        0, 4107, 8149, 12063, 15786, 19261, 22431,
        25248, 27667, 29649, 31164, 32188, 32703
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Full-wave cosine at step k (0..50)
    function automatic int full_cos(input int k);
        if (k <= 12) return COS_Q[k];
        if (k <= 25) return -COS_Q[25 - k];
        if (k <= 37) return -COS_Q[k - 25];
        return COS_Q[50 - k];
    endfunction

    // Full-wave sine at step k (0..50)
    function automatic int full_sin(input int k);
        if (k <= 12) return SIN_Q[k];
        if (k <= 25) return SIN_Q[25 - k];
        if (k <= 37) return -SIN_Q[k - 25];
        return -SIN_Q[50 - k];
    endfunction

    // Saturate +1.0 and rescale Q1.15 to the coefficient width
    function automatic int rescale(input int q15, input int coef_bits);
        int v;
        v = (q15 > 32767) ? 32767 : q15;
        if (coef_bits >= 16) return v <<< (coef_bits - 16);
        return (v + (1 <<< (15 - coef_bits))) >>> (16 - coef_bits);
    endfunction

    // Cosine coefficient for window position pos (0 is newest)
    function automatic logic signed [COEF_MAX_BITS-1:0] coef_cos(
        input int pos, input int coef_bits);
        if (pos >= ROM_LEN) return '0;
        return COEF_MAX_BITS'(rescale(full_cos(pos + 1), coef_bits));
    endfunction

    // Sine coefficient for window position pos (0 is newest)
    function automatic logic signed [COEF_MAX_BITS-1:0] coef_sin(
        input int pos, input int coef_bits);
        if (pos >= ROM_LEN) return '0;
        return COEF_MAX_BITS'(rescale(-full_sin(pos + 1), coef_bits));
    endfunction

endpackage

/* hw/rtl/swdft_if.sv */
// ============================================================================
// swdft_in_if / swdft_out_if
// Valid/ready channels for the sample beats and the phasor result beats.
// ============================================================================
interface swdft_in_if #(
    parameter int SAMPLE_BITS = swdft_pkg::SAMPLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [SAMPLE_BITS-1:0]       sample;
    logic                         time_valid;
    logic [swdft_pkg::TIME_W-1:0] time_value;

    modport source (output valid, sample, time_valid, time_value, input ready);
    modport sink   (input valid, sample, time_valid, time_value, output ready);
endinterface

interface swdft_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [swdft_pkg::ACC_W-1:0]  real_part;
    logic signed [swdft_pkg::ACC_W-1:0]  imag_part;
    logic [swdft_pkg::TIME_W-1:0]        time_tag;
    logic [swdft_pkg::COUNT_W-1:0]       sample_count;

    modport source (output valid, real_part, imag_part, time_tag, sample_count,
                    input ready);
    modport sink   (input valid, real_part, imag_part, time_tag, sample_count,
                    output ready);
endinterface

/* hw/rtl/sliding_window_dft_phasor.sv */
// ============================================================================
// sliding_window_dft_phasor
// Full-cycle DFT phasor estimator: keeps the most recent samples in a
// circular buffer and recomputes the cosine and sine sums over the whole
// window with one shared multiply-accumulate pair.
// ============================================================================
//
//  channel | dir | beat contents                                | handshake
//  --------+-----+----------------------------------------------+-----------
//  i_in    | in  | sample, time_valid, time_value               | valid/ready
//  o_out   | out | real_part, imag_part, time_tag, sample_count | valid/ready
//
//  One input beat occupies the block from its acceptance until its result is
//  loaded and the block is back in idle; no new beat is taken in between. The
//  block sweeps the single read port one window position a cycle, then drains
//  the multiply/accumulate stages, detects the empty pipe, loads the output
//  register and returns to idle for the next beat.
//  A finished result sits in the output register, so the next input beat is
//  accepted while the previous result waits; a result that is done while the
//  output register is still full holds the block until o_out.ready.
//  Reset clears the window valid bits, time stamp and counter.
//
module sliding_window_dft_phasor #(
    parameter int WINDOW_LEN  = swdft_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = swdft_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = swdft_pkg::COEF_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swdft_in_if.sink    i_in,
    swdft_out_if.source o_out
);

    localparam int ADDR_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int XW      = SAMPLE_BITS + 1;
    localparam int PW      = XW + COEF_BITS;
    localparam int MID_VAL = 2 ** (SAMPLE_BITS - 1);
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(WINDOW_LEN - 1);

    // Window memory and per-entry valid bits
    logic [SAMPLE_BITS-1:0] mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0]  r_vld;

    swdft_pkg::t_state r_state, n_state;

    logic [ADDR_W-1:0] r_wptr;
    logic [ADDR_W-1:0] r_raddr;
    logic [ADDR_W-1:0] r_pos;

    logic [swdft_pkg::TIME_W-1:0]  r_time;
    logic [swdft_pkg::COUNT_W-1:0] r_cnt;

    // Stage 1: read data and coefficients
    logic                        r_s1_v;
    logic [SAMPLE_BITS-1:0]      r_rd_data;
    logic                        r_rd_vld;
    logic signed [COEF_BITS-1:0] r_cos;
    logic signed [COEF_BITS-1:0] r_sin;

    // Stage 2: products
    logic                 r_s2_v;
    logic signed [PW-1:0] r_prod_re;
    logic signed [PW-1:0] r_prod_im;

    logic signed [swdft_pkg::ACC_W-1:0] r_acc_re;
    logic signed [swdft_pkg::ACC_W-1:0] r_acc_im;

    // Output register
    logic                                r_out_valid;
    logic signed [swdft_pkg::ACC_W-1:0]  r_out_re;
    logic signed [swdft_pkg::ACC_W-1:0]  r_out_im;
    logic [swdft_pkg::TIME_W-1:0]        r_out_time;
    logic [swdft_pkg::COUNT_W-1:0]       r_out_cnt;

    logic w_accept;
    logic w_issue;
    logic w_load;
    logic w_ready;

    logic [SAMPLE_BITS-1:0] w_samp;
    logic signed [XW-1:0]   w_x;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swdft_pkg::ST_IDLE:  if (w_accept) n_state = swdft_pkg::ST_RUN;
            swdft_pkg::ST_RUN:   if (r_pos == LAST) n_state = swdft_pkg::ST_DRAIN;
            swdft_pkg::ST_DRAIN: if (!r_s1_v && !r_s2_v) n_state = swdft_pkg::ST_DONE;
            swdft_pkg::ST_DONE:  if (!r_out_valid || o_out.ready) n_state = swdft_pkg::ST_IDLE;
            default:             n_state = swdft_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_ready = 1'b0;
        w_issue = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            swdft_pkg::ST_IDLE:  w_ready = 1'b1;
            swdft_pkg::ST_RUN:   w_issue = 1'b1;
            swdft_pkg::ST_DRAIN: w_issue = 1'b0;
            swdft_pkg::ST_DONE:  w_load  = !r_out_valid || o_out.ready;
            default:             w_ready = 1'b0;
        endcase
    end

    assign i_in.ready = w_ready;
    assign w_accept   = i_in.valid && w_ready;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swdft_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Write the new sample, read one window position a cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            mem[r_wptr] <= i_in.sample;
        end
        r_rd_data <= mem[r_raddr];
    end

    // Valid bits, pointers, time stamp and counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_wptr   <= '0;
            r_raddr  <= '0;
            r_pos    <= '0;
            r_time   <= '0;
            r_cnt    <= '0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[r_raddr];
            r_s1_v   <= w_issue;
            r_s2_v   <= r_s1_v;
            if (w_accept) begin
                r_vld[r_wptr] <= 1'b1;
                r_raddr       <= r_wptr;
                r_wptr        <= (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
                r_pos         <= '0;
                if (i_in.time_valid) begin
                    r_time <= i_in.time_value;
                    r_cnt  <= '0;
                end
            end else if (w_issue) begin
                r_raddr <= (r_raddr == '0) ? LAST : r_raddr - 1'b1;
                r_pos   <= r_pos + 1'b1;
            end
            // Count each result loaded into the output register, saturating at all ones
            if (w_load && r_cnt != '1) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Look up coefficients for the position being read
    always_ff @(posedge i_clk) begin
        r_cos <= COEF_BITS'(swdft_pkg::coef_cos(int'(r_pos), COEF_BITS));
        r_sin <= COEF_BITS'(swdft_pkg::coef_sin(int'(r_pos), COEF_BITS));
    end

    // Center the sample; an unwritten entry reads as zero
    assign w_samp = r_rd_vld ? r_rd_data : '0;
    assign w_x    = $signed({1'b0, w_samp} - XW'(MID_VAL));

    // Multiply, then accumulate modulo the result width
    always_ff @(posedge i_clk) begin
        r_prod_re <= w_x * r_cos;
        r_prod_im <= w_x * r_sin;
        if (w_accept) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_s2_v) begin
            r_acc_re <= r_acc_re + swdft_pkg::ACC_W'(r_prod_re);
            r_acc_im <= r_acc_im + swdft_pkg::ACC_W'(r_prod_im);
        end
    end

    // Hold the result until the sink takes the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_re   <= r_acc_re;
            r_out_im   <= r_acc_im;
            r_out_time <= r_time;
            r_out_cnt  <= r_cnt;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.real_part    = r_out_re;
    assign o_out.imag_part    = r_out_im;
    assign o_out.time_tag     = r_out_time;
    assign o_out.sample_count = r_out_cnt;

endmodule

/* tb/tb_top.sv */
// ============================================================================
// tb_top
// Self-checking bench for the sliding-window DFT phasor estimator. Sample
// beats go in with random gaps, result beats come out under random back
// pressure, and every result is compared field by field with a software
// copy of the window, the coefficient ROM, the time latch and the counter.
// ============================================================================

// Expected phasors, built from a private copy of the window state
class phasor_scoreboard;

    typedef struct {
        logic signed [swdft_pkg::ACC_W-1:0] re;
        logic signed [swdft_pkg::ACC_W-1:0] im;
        logic [swdft_pkg::TIME_W-1:0]       ts;
        logic [swdft_pkg::COUNT_W-1:0]      cnt;
    } t_phasor;

    int                            cos_coef [swdft_pkg::WINDOW_LEN_DEF];
    int                            sin_coef [swdft_pkg::WINDOW_LEN_DEF];
    logic [11:0]                   win      [swdft_pkg::WINDOW_LEN_DEF];
    logic [swdft_pkg::TIME_W-1:0]  held_time;
    logic [swdft_pkg::COUNT_W-1:0] count;
    t_phasor                       expected [$];
    int                            mismatches;

    function new();
        int cq [13];
        int sq [13];
        int k;
        int c;
        int s;
        cq = '{32768, 32510, 31739, 30467, 28715, 26510, 23887,
               20887, 17558, 13952, 10126, 6140, 2058};
        sq = '{0, 4107, 8149, 12063, 15786, 19261, 22431,
               25248, 27667, 29649, 31164, 32188, 32703};
        // Unfold the quarter wave; position i sits at angle step i+1
        for (int i = 0; i < swdft_pkg::WINDOW_LEN_DEF; i++) begin
            k = i + 1;
            if (k <= 12) begin
                c = cq[k];
                s = sq[k];
            end else if (k <= 25) begin
                c = -cq[25 - k];
                s = sq[25 - k];
            end else if (k <= 37) begin
                c = -cq[k - 25];
                s = -sq[k - 25];
            end else begin
                c = cq[50 - k];
                s = -sq[50 - k];
            end
            s = -s;
            // Clip +1.0 into Q1.15
            if (c > 32767) c = 32767;
            if (s > 32767) s = 32767;
            cos_coef[i] = c;
            sin_coef[i] = s;
            win[i] = '0;
        end
        held_time  = '0;
        count      = '0;
        mismatches = 0;
    endfunction

    // Advance the window with an accepted sample beat and queue its phasor
    function void add_sample(logic [11:0] smp, logic tv, logic [swdft_pkg::TIME_W-1:0] tval);
        longint  re_sum;
        longint  im_sum;
        longint  x;
        t_phasor p;
        if (tv) begin
            held_time = tval;
            count     = '0;
        end
        for (int i = swdft_pkg::WINDOW_LEN_DEF - 1; i > 0; i--) win[i] = win[i - 1];
        win[0] = smp;
        re_sum = 0;
        im_sum = 0;
        for (int i = 0; i < swdft_pkg::WINDOW_LEN_DEF; i++) begin
            x = longint'(win[i]) - 2048;
            re_sum += x * cos_coef[i];
            im_sum += x * sin_coef[i];
        end
        p.re  = re_sum[swdft_pkg::ACC_W-1:0];
        p.im  = im_sum[swdft_pkg::ACC_W-1:0];
        p.ts  = held_time;
        p.cnt = count;
        expected.push_back(p);
        // Hold the counter at its ceiling
        if (count != {swdft_pkg::COUNT_W{1'b1}}) count++;
    endfunction

    // Compare one result beat with the oldest queued phasor
    function void check_phasor(logic signed [swdft_pkg::ACC_W-1:0] re,
                               logic signed [swdft_pkg::ACC_W-1:0] im,
                               logic [swdft_pkg::TIME_W-1:0] ts,
                               logic [swdft_pkg::COUNT_W-1:0] cnt);
        t_phasor p;
        if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: re=%0d im=%0d ts=%0d cnt=%0d",
                         re, im, ts, cnt);
            return;
        end
        p = expected.pop_front();
        if (p.re !== re || p.im !== im || p.ts !== ts || p.cnt !== cnt) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result mismatch: exp re=%0d im=%0d ts=%0d cnt=%0d",
                         p.re, p.im, p.ts, p.cnt);
                $display("                 got re=%0d im=%0d ts=%0d cnt=%0d",
                         re, im, ts, cnt);
            end
        end
    endfunction

endclass

module tb_top;

    localparam int IDLE_PCT     = 34;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 120;

    typedef enum int {
        PAT_UNIFORM,
        PAT_FULL,
        PAT_EMPTY,
        PAT_TOGGLE,
        PAT_SINE,
        PAT_MID_NOISE
    } t_pattern;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm;
    int   cycles;

    phasor_scoreboard sb;

    swdft_in_if  in_if ();
    swdft_out_if out_if ();

    sliding_window_dft_phasor DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Check result beats and toggle back pressure
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_phasor(out_if.real_part, out_if.imag_part,
                            out_if.time_tag, out_if.sample_count);
        out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Present one sample beat, idling at random first, and wait for acceptance
    task automatic send_beat(input logic [11:0] smp, input logic tv,
                             input logic [swdft_pkg::TIME_W-1:0] tval);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.sample     <= smp;
        in_if.time_valid <= tv;
        in_if.time_value <= tval;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.add_sample(smp, tv, tval);
    endtask

    initial begin
        t_pattern                     pat;
        int                           phase;
        logic [11:0]                  smp;
        logic                         tv;
        logic [swdft_pkg::TIME_W-1:0] tval;

        sb = new();
        calm             = 1'b0;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.sample     <= '0;
        in_if.time_valid <= 1'b0;
        in_if.time_value <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset window, sample extremes, time latch extremes
        send_beat(12'd2048, 1'b0, 14'd0);
        send_beat(12'd0,    1'b0, 14'h3FFF);
        send_beat(12'd4095, 1'b0, 14'd0);
        send_beat(12'd4095, 1'b1, 14'h3FFF);
        send_beat(12'd4095, 1'b0, 14'd0);
        send_beat(12'd0,    1'b1, 14'd0);
        send_beat(12'd0,    1'b0, 14'd1234);
        send_beat(12'd2047, 1'b0, 14'd0);
        send_beat(12'd2049, 1'b0, 14'd0);
        send_beat(12'h555,  1'b1, 14'd9999);
        send_beat(12'hAAA,  1'b0, 14'd0);
        send_beat(12'h555,  1'b0, 14'd0);
        send_beat(12'hAAA,  1'b1, 14'h2AAA);
        send_beat(12'd1,    1'b1, 14'h1555);
        send_beat(12'd4094, 1'b0, 14'd0);
        send_beat(12'd4095, 1'b1, 14'd10000);
        send_beat(12'd0,    1'b0, 14'd0);
        send_beat(12'd4095, 1'b0, 14'd0);
        send_beat(12'd0,    1'b0, 14'd0);
        send_beat(12'd2048, 1'b1, 14'd1);
        send_beat(12'd2048, 1'b0, 14'd0);

        // Random: segments of one waveform pattern each, time marks sprinkled in
        for (int seg = 0; seg < 18; seg++) begin
            pat   = t_pattern'($urandom_range(5));
            phase = $urandom_range(49);
            calm  = (seg >= 8 && seg < 11);
            for (int n = 0; n < 50; n++) begin
                case (pat)
                    PAT_FULL:      smp = 12'd4095;
                    PAT_EMPTY:     smp = 12'd0;
                    PAT_TOGGLE:    smp = n[0] ? 12'd4095 : 12'd0;
                    PAT_SINE:      smp = 12'(2048 + (sb.cos_coef[(phase + n) % 50] >>> 4));
                    PAT_MID_NOISE: smp = 12'(2040 + $urandom_range(16));
                    default:       smp = 12'($urandom_range(4095));
                endcase
                tv   = ($urandom_range(24) == 0);
                tval = ($urandom_range(3) == 0) ? 14'd9999 : 14'($urandom_range(16383));
                send_beat(smp, tv, tval);
            end
        end

        // Close with a fresh time mark and one beat after it
        calm = 1'b0;
        send_beat(12'($urandom_range(4095)), 1'b1, 14'd42);
        send_beat(12'($urandom_range(4095)), 1'b0, 14'd0);

        // Drain
        in_if.valid <= 1'b0;
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
